// ===== hw/rtl/lcm_pkg.sv =====
package lcm_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int PIX_TOTAL = MAX_ROWS * MAX_COLS;

    localparam int IDX_W  = $clog2(PIX_TOTAL);
    localparam int TOT_W  = $clog2(PIX_TOTAL + 1);
    localparam int RDW    = $clog2(MAX_ROWS + 1);
    localparam int CDW    = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CFG_W  = 9;
    localparam int PIX_W  = 8;
    localparam int SIZE_W = 16;

    localparam logic [PIX_W-1:0]  PIX_ON     = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_OFF    = 8'd0;
    localparam logic [PIX_W-1:0]  PIX_THRESH = 8'd127;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 16'hFFFF;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef enum logic {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic keep;
        logic visited;
    } t_mark;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_stk_ent;

    typedef struct packed {
        logic             pix_we;
        logic [IDX_W-1:0] pix_waddr;
        logic [PIX_W-1:0] pix_wdata;
        logic [IDX_W-1:0] pix_raddr;
        logic             mark_we;
        logic [IDX_W-1:0] mark_waddr;
        t_mark            mark_wdata;
        logic [IDX_W-1:0] mark_raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        F_IDLE,
        F_CLEAR,
        F_SCAN_RD,
        F_SCAN_CHK,
        F_POP,
        F_POP_WAIT,
        F_NB,
        F_NB_WAIT,
        F_END
    } t_fill_state;

    function automatic logic [RDW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [RDW-1:0] res;
        if (v == '0) begin
            res = RDW'(1);
        end else if (32'(v) > MAX_ROWS) begin
            res = RDW'(MAX_ROWS);
        end else begin
            res = RDW'(v);
        end
        return res;
    endfunction

    function automatic logic [CDW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [CDW-1:0] res;
        if (v == '0) begin
            res = CDW'(1);
        end else if (32'(v) > MAX_COLS) begin
            res = CDW'(MAX_COLS);
        end else begin
            res = CDW'(v);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/lcm_store.sv =====
module lcm_store (
    input  logic                        i_clk,
    input  lcm_pkg::t_mem_req           i_req,
    output logic [lcm_pkg::PIX_W-1:0]   o_pix_q,
    output lcm_pkg::t_mark              o_mark_q
);

    logic [lcm_pkg::PIX_W-1:0] mem_pix  [lcm_pkg::PIX_TOTAL];
    lcm_pkg::t_mark            mem_mark [lcm_pkg::PIX_TOTAL];

    always_ff @(posedge i_clk) begin
        if (i_req.pix_we) begin
            mem_pix[i_req.pix_waddr] <= i_req.pix_wdata;
        end
        o_pix_q <= mem_pix[i_req.pix_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mark_we) begin
            mem_mark[i_req.mark_waddr] <= i_req.mark_wdata;
        end
        o_mark_q <= mem_mark[i_req.mark_raddr];
    end

endmodule

// ===== hw/rtl/lcm_fill.sv =====
module lcm_fill (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lcm_pkg::RDW-1:0]     i_rows,
    input  logic [lcm_pkg::CDW-1:0]     i_cols,
    input  logic [lcm_pkg::TOT_W-1:0]   i_total,
    input  logic [lcm_pkg::PIX_W-1:0]   i_pix_q,
    input  lcm_pkg::t_mark              i_mark_q,
    output lcm_pkg::t_mem_req           o_req,
    output logic                        o_busy,
    output logic [lcm_pkg::TOT_W-1:0]   o_best_size
);

    lcm_pkg::t_fill_state r_state, n_state;
    logic                        r_pass, n_pass;
    logic                        r_have, n_have;
    logic                        r_keep, n_keep;
    logic [lcm_pkg::TOT_W-1:0]   r_i, n_i;
    logic [lcm_pkg::RDW-1:0]     r_sr, n_sr;
    logic [lcm_pkg::CDW-1:0]     r_sc, n_sc;
    logic [lcm_pkg::TOT_W-1:0]   r_sp, n_sp;
    logic [lcm_pkg::TOT_W-1:0]   r_cnt, n_cnt;
    logic [lcm_pkg::TOT_W-1:0]   r_best, n_best;
    logic [lcm_pkg::IDX_W-1:0]   r_seed, n_seed;
    logic [1:0]                  r_k, n_k;
    lcm_pkg::t_stk_ent           r_cur, n_cur;
    lcm_pkg::t_stk_ent           r_nb, n_nb;

    lcm_pkg::t_stk_ent           mem_stk [lcm_pkg::PIX_TOTAL];
    lcm_pkg::t_stk_ent           r_stk_q;
    logic                        stk_we;
    logic [lcm_pkg::IDX_W-1:0]   stk_waddr;
    logic [lcm_pkg::IDX_W-1:0]   stk_raddr;
    lcm_pkg::t_stk_ent           stk_wdata;

    logic [lcm_pkg::TOT_W-1:0]   sp_dec;
    logic [lcm_pkg::RDW-1:0]     cur_r;
    logic [lcm_pkg::CDW-1:0]     cur_c;
    logic [lcm_pkg::RDW-1:0]     nb_r;
    logic [lcm_pkg::CDW-1:0]     nb_c;
    logic [lcm_pkg::IDX_W-1:0]   nb_idx;
    logic                        nb_inner;
    logic                        seed_inner;

    function automatic logic is_inner(
        input logic [lcm_pkg::RDW-1:0] r,
        input logic [lcm_pkg::CDW-1:0] c,
        input logic [lcm_pkg::RDW-1:0] rows,
        input logic [lcm_pkg::CDW-1:0] cols
    );
        return (r != '0) && (r < rows - 1'b1) && (c != '0) && (c < cols - 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= mem_stk[stk_raddr];
    end

    // neighbor order: up, right, left, down
    always_comb begin
        cur_r = lcm_pkg::RDW'(r_cur.row);
        cur_c = lcm_pkg::CDW'(r_cur.col);
        case (r_k)
            2'd0: begin
                nb_r   = cur_r - 1'b1;
                nb_c   = cur_c;
                nb_idx = r_cur.idx - lcm_pkg::IDX_W'(i_cols);
            end
            2'd1: begin
                nb_r   = cur_r;
                nb_c   = cur_c + 1'b1;
                nb_idx = r_cur.idx + 1'b1;
            end
            2'd2: begin
                nb_r   = cur_r;
                nb_c   = cur_c - 1'b1;
                nb_idx = r_cur.idx - 1'b1;
            end
            default: begin
                nb_r   = cur_r + 1'b1;
                nb_c   = cur_c;
                nb_idx = r_cur.idx + lcm_pkg::IDX_W'(i_cols);
            end
        endcase
        nb_inner   = is_inner(nb_r, nb_c, i_rows, i_cols);
        seed_inner = is_inner(r_sr, r_sc, i_rows, i_cols);
        sp_dec     = r_sp - 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_pass    = r_pass;
        n_have    = r_have;
        n_keep    = r_keep;
        n_i       = r_i;
        n_sr      = r_sr;
        n_sc      = r_sc;
        n_sp      = r_sp;
        n_cnt     = r_cnt;
        n_best    = r_best;
        n_seed    = r_seed;
        n_k       = r_k;
        n_cur     = r_cur;
        n_nb      = r_nb;
        o_req     = '0;
        stk_we    = 1'b0;
        stk_waddr = r_sp[lcm_pkg::IDX_W-1:0];
        stk_wdata = r_nb;
        stk_raddr = sp_dec[lcm_pkg::IDX_W-1:0];

        case (r_state)
            lcm_pkg::F_IDLE: begin
                if (i_start) begin
                    n_pass  = 1'b0;
                    n_have  = 1'b0;
                    n_best  = '0;
                    n_seed  = '0;
                    n_i     = '0;
                    n_state = lcm_pkg::F_CLEAR;
                end
            end
            lcm_pkg::F_CLEAR: begin
                o_req.mark_we    = 1'b1;
                o_req.mark_waddr = r_i[lcm_pkg::IDX_W-1:0];
                if (r_i == i_total - 1'b1) begin
                    n_i     = '0;
                    n_sr    = '0;
                    n_sc    = '0;
                    n_state = lcm_pkg::F_SCAN_RD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            lcm_pkg::F_SCAN_RD: begin
                if (r_i == i_total) begin
                    if (!r_pass && r_have) begin
                        n_pass  = 1'b1;
                        n_i     = '0;
                        n_state = lcm_pkg::F_CLEAR;
                    end else begin
                        n_state = lcm_pkg::F_IDLE;
                    end
                end else begin
                    o_req.pix_raddr  = r_i[lcm_pkg::IDX_W-1:0];
                    o_req.mark_raddr = r_i[lcm_pkg::IDX_W-1:0];
                    n_state          = lcm_pkg::F_SCAN_CHK;
                end
            end
            lcm_pkg::F_SCAN_CHK: begin
                if (i_pix_q != '0 && !i_mark_q.visited) begin
                    n_keep = r_pass && (r_i[lcm_pkg::IDX_W-1:0] == r_seed);
                    if (seed_inner) begin
                        o_req.mark_we      = 1'b1;
                        o_req.mark_waddr   = r_i[lcm_pkg::IDX_W-1:0];
                        o_req.mark_wdata   = '{keep: n_keep, visited: 1'b1};
                        n_cnt              = lcm_pkg::TOT_W'(1);
                    end else begin
                        n_cnt = '0;
                    end
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = '{idx: r_i[lcm_pkg::IDX_W-1:0],
                                  row: r_sr[lcm_pkg::ROW_W-1:0],
                                  col: r_sc[lcm_pkg::COL_W-1:0]};
                    n_sp      = lcm_pkg::TOT_W'(1);
                    n_state   = lcm_pkg::F_POP;
                end else begin
                    n_i = r_i + 1'b1;
                    if (r_sc == i_cols - 1'b1) begin
                        n_sc = '0;
                        n_sr = r_sr + 1'b1;
                    end else begin
                        n_sc = r_sc + 1'b1;
                    end
                    n_state = lcm_pkg::F_SCAN_RD;
                end
            end
            lcm_pkg::F_POP: begin
                if (r_sp == '0) begin
                    n_state = lcm_pkg::F_END;
                end else begin
                    n_sp    = sp_dec;
                    n_state = lcm_pkg::F_POP_WAIT;
                end
            end
            lcm_pkg::F_POP_WAIT: begin
                n_cur   = r_stk_q;
                n_k     = '0;
                n_state = lcm_pkg::F_NB;
            end
            lcm_pkg::F_NB: begin
                if (nb_inner) begin
                    o_req.pix_raddr  = nb_idx;
                    o_req.mark_raddr = nb_idx;
                    n_nb    = '{idx: nb_idx, row: nb_r[lcm_pkg::ROW_W-1:0],
                                col: nb_c[lcm_pkg::COL_W-1:0]};
                    n_state = lcm_pkg::F_NB_WAIT;
                end else if (r_k == 2'd3) begin
                    n_state = lcm_pkg::F_POP;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            lcm_pkg::F_NB_WAIT: begin
                if (i_pix_q != '0 && !i_mark_q.visited) begin
                    o_req.mark_we    = 1'b1;
                    o_req.mark_waddr = r_nb.idx;
                    o_req.mark_wdata = '{keep: r_keep, visited: 1'b1};
                    n_cnt            = r_cnt + 1'b1;
                    if (r_sp < lcm_pkg::TOT_W'(lcm_pkg::PIX_TOTAL)) begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + 1'b1;
                    end
                end
                if (r_k == 2'd3) begin
                    n_state = lcm_pkg::F_POP;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = lcm_pkg::F_NB;
                end
            end
            lcm_pkg::F_END: begin
                if (!r_pass && (!r_have || r_cnt > r_best)) begin
                    n_best = r_cnt;
                    n_seed = r_i[lcm_pkg::IDX_W-1:0];
                    n_have = 1'b1;
                end
                n_i = r_i + 1'b1;
                if (r_sc == i_cols - 1'b1) begin
                    n_sc = '0;
                    n_sr = r_sr + 1'b1;
                end else begin
                    n_sc = r_sc + 1'b1;
                end
                n_state = lcm_pkg::F_SCAN_RD;
            end
            default: begin
                n_state = lcm_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcm_pkg::F_IDLE;
            r_pass  <= 1'b0;
            r_have  <= 1'b0;
            r_best  <= '0;
            r_seed  <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_have  <= n_have;
            r_best  <= n_best;
            r_seed  <= n_seed;
            r_sp    <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keep <= n_keep;
        r_i    <= n_i;
        r_sr   <= n_sr;
        r_sc   <= n_sc;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_cur  <= n_cur;
        r_nb   <= n_nb;
    end

    assign o_busy      = (r_state != lcm_pkg::F_IDLE);
    assign o_best_size = r_best;

endmodule

// ===== hw/rtl/largest_component_mask_core.sv =====
// Largest 4-connected interior region mask.
// Input stream: tuser[0] is the action (load or read), tdata[7:0] the pixel
// for a load. Loads fill the image in raster order, one per cycle while
// tready is high. The last load of a row_count x col_count image starts the
// region search; tready stays low until it is done. The search clears the
// mark memory and scans every pixel, and does both again if a region was
// found; the stack walk checks the four neighbours of each claimed pixel,
// all through one write and one read port per pixel, mark and stack memory.
// A read transaction after a complete image gives one output transaction,
// registered in r_pend and then the output register: tdata[7:0] is 0 or 255,
// tdata[23:8] the kept region size, tlast marks the final pixel. No read is
// taken while one is pending; reads before a complete image give nothing.
// When the receiver stalls the output register holds and no further read is
// taken. Reset sets both sizes to 256 and empties the image; the config port
// changes a size and restarts loading. The memories are not cleared by reset.
module largest_component_mask_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel_value
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mask_pixel, region_size
    output logic        m_axis_tlast,   // last_pixel
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);

    logic [lcm_pkg::RDW-1:0]    r_rows;
    logic [lcm_pkg::CDW-1:0]    r_cols;
    logic [lcm_pkg::TOT_W-1:0]  r_lidx;
    logic [lcm_pkg::TOT_W-1:0]  r_ridx;
    logic [lcm_pkg::RDW-1:0]    r_rr;
    logic [lcm_pkg::CDW-1:0]    r_rc;
    logic                       r_pend;
    logic                       r_border;
    logic                       r_last;
    logic                       r_ovalid;
    logic [lcm_pkg::PIX_W-1:0]  r_omask;
    logic [lcm_pkg::SIZE_W-1:0] r_osize;
    logic                       r_olast;

    logic [lcm_pkg::TOT_W-1:0]  total;
    logic [lcm_pkg::TOT_W-1:0]  lidx_eff;
    logic [lcm_pkg::TOT_W-1:0]  lidx_inc;
    logic                       ready;
    logic                       acc;
    logic                       is_load;
    logic                       loaded;
    logic                       start;
    logic                       rd_go;
    logic                       fill_busy;
    logic [lcm_pkg::TOT_W-1:0]  best_size;
    lcm_pkg::t_mem_req          fill_req;
    lcm_pkg::t_mem_req          top_req;
    lcm_pkg::t_mem_req          req;
    logic [lcm_pkg::PIX_W-1:0]  pix_q;
    lcm_pkg::t_mark             mark_q;

    always_comb begin
        total    = lcm_pkg::TOT_W'(r_rows * r_cols);
        ready    = !fill_busy && !r_pend && (!r_ovalid || m_axis_tready);
        acc      = s_axis_tvalid && ready;
        is_load  = (lcm_pkg::t_action'(s_axis_tuser[0]) == lcm_pkg::ACT_LOAD);
        loaded   = (r_lidx == total);
        lidx_eff = (r_lidx >= total) ? '0 : r_lidx;
        lidx_inc = lidx_eff + 1'b1;
        start    = acc && is_load && (lidx_inc == total);
        rd_go    = acc && !is_load && loaded;

        top_req            = '0;
        top_req.pix_we     = acc && is_load;
        top_req.pix_waddr  = lidx_eff[lcm_pkg::IDX_W-1:0];
        top_req.pix_wdata  = s_axis_tdata;
        top_req.pix_raddr  = r_ridx[lcm_pkg::IDX_W-1:0];
        top_req.mark_raddr = r_ridx[lcm_pkg::IDX_W-1:0];
        req                = fill_busy ? fill_req : top_req;
    end

    lcm_store u_store (
        .i_clk    (i_clk),
        .i_req    (req),
        .o_pix_q  (pix_q),
        .o_mark_q (mark_q)
    );

    lcm_fill u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_rows      (r_rows),
        .i_cols      (r_cols),
        .i_total     (total),
        .i_pix_q     (pix_q),
        .i_mark_q    (mark_q),
        .o_req       (fill_req),
        .o_busy      (fill_busy),
        .o_best_size (best_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= lcm_pkg::RDW'(lcm_pkg::MAX_ROWS);
            r_cols   <= lcm_pkg::CDW'(lcm_pkg::MAX_COLS);
            r_lidx   <= '0;
            r_ridx   <= '0;
            r_rr     <= '0;
            r_rc     <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (lcm_pkg::t_cfg_reg'(i_cfg_idx[0]) == lcm_pkg::CFG_ROW_COUNT) begin
                    r_rows <= lcm_pkg::clamp_rows(i_cfg_data);
                end else begin
                    r_cols <= lcm_pkg::clamp_cols(i_cfg_data);
                end
                r_lidx <= '0;
                r_ridx <= '0;
                r_rr   <= '0;
                r_rc   <= '0;
            end else if (acc && is_load) begin
                r_lidx <= lidx_inc;
                if (start) begin
                    r_ridx <= '0;
                    r_rr   <= '0;
                    r_rc   <= '0;
                end
            end else if (rd_go) begin
                if (r_ridx == total - 1'b1) begin
                    r_ridx <= '0;
                    r_rr   <= '0;
                    r_rc   <= '0;
                end else begin
                    r_ridx <= r_ridx + 1'b1;
                    if (r_rc == r_cols - 1'b1) begin
                        r_rc <= '0;
                        r_rr <= r_rr + 1'b1;
                    end else begin
                        r_rc <= r_rc + 1'b1;
                    end
                end
            end

            r_pend <= rd_go;
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_border <= (r_rr == '0) || (r_rr == r_rows - 1'b1) ||
                        (r_rc == '0) || (r_rc == r_cols - 1'b1);
            r_last   <= (r_ridx == total - 1'b1);
        end
        if (r_pend) begin
            r_omask <= (pix_q > lcm_pkg::PIX_THRESH && (r_border || mark_q.keep)) ?
                       lcm_pkg::PIX_ON : lcm_pkg::PIX_OFF;
            r_osize <= (best_size > lcm_pkg::TOT_W'(lcm_pkg::SIZE_MAX)) ?
                       lcm_pkg::SIZE_MAX : best_size[lcm_pkg::SIZE_W-1:0];
            r_olast <= r_last;
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_osize, r_omask};
    assign m_axis_tlast  = r_olast;

endmodule
